// File: hdl/radar_measurement_jacobian_top_macros.svh
// assertion macros shared by the rtl
`ifndef RADAR_MEASUREMENT_JACOBIAN_TOP_MACROS_SVH
`define RADAR_MEASUREMENT_JACOBIAN_TOP_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define RMJ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rmj assertion failed");

// checked on every edge, reset included
`define RMJ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("rmj assertion failed");

`else

`define RMJ_ASSERT(lbl, prop)
`define RMJ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// File: hdl/rmj_pkg.sv
package rmj_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned QuotW     = 32;
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned R2W       = 64;

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] drho_dpx;
    logic signed [DataW-1:0] drho_dpy;
    logic signed [DataW-1:0] dphi_dpx;
    logic signed [DataW-1:0] dphi_dpy;
    logic signed [DataW-1:0] drate_dpx;
    logic signed [DataW-1:0] drate_dpy;
    logic                    singular;
  } out_t;

  // partial remainder and root handed from one square root cell to the next
  typedef struct packed {
    logic [R2W-1:0] rem;
    logic [R2W-1:0] root;
  } sqrt_t;

endpackage

// File: hdl/rmj_sqrt_cell.sv
module rmj_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  rmj_pkg::sqrt_t sq_i,
  output rmj_pkg::sqrt_t sq_o
);

  localparam int unsigned BitPos = 2 * (rmj_pkg::SqrtSteps - 1 - STEP);
  localparam logic [rmj_pkg::R2W-1:0] Bit = rmj_pkg::R2W'(1) << BitPos;

  rmj_pkg::sqrt_t sq_d, sq_q;
  logic [rmj_pkg::R2W-1:0] trial;

  always_comb begin
    trial = sq_i.root + Bit;
    if (sq_i.rem >= trial) begin
      sq_d.rem  = sq_i.rem - trial;
      sq_d.root = (sq_i.root >> 1) + Bit;
    end else begin
      sq_d.rem  = sq_i.rem;
      sq_d.root = sq_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// File: hdl/rmj_div_cell.sv
module rmj_div_cell #(
  parameter int unsigned W   = 128,
  parameter int unsigned BIT = 0
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [W-1:0]              rem_i,
  input  logic [W-1:0]              div_i,
  input  logic [rmj_pkg::QuotW-1:0] quo_i,
  input  logic                      ovf_i,
  output logic [W-1:0]              rem_o,
  output logic [W-1:0]              div_o,
  output logic [rmj_pkg::QuotW-1:0] quo_o,
  output logic                      ovf_o
);

  logic [W-1:0]              dsh;
  logic                      ge;
  logic [W-1:0]              rem_d, rem_q, div_q;
  logic [rmj_pkg::QuotW-1:0] quo_d, quo_q;
  logic                      ovf_q;

  always_comb begin
    dsh   = div_i << BIT;
    ge    = (rem_i >= dsh);
    rem_d = ge ? (rem_i - dsh) : rem_i;
    quo_d = {quo_i[rmj_pkg::QuotW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      div_q <= div_i;
      quo_q <= quo_d;
      ovf_q <= ovf_i;
    end
  end

  assign rem_o = rem_q;
  assign div_o = div_q;
  assign quo_o = quo_q;
  assign ovf_o = ovf_q;

endmodule

// File: hdl/rmj_div_chain.sv
module rmj_div_chain #(
  parameter int unsigned NW = 48,
  parameter int unsigned DW = 32
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [NW-1:0]             num_i,
  input  logic [DW-1:0]             den_i,
  output logic [rmj_pkg::QuotW-1:0] quo_o,
  output logic                      ovf_o
);

  localparam int unsigned W = (NW > DW + rmj_pkg::QuotW) ? NW : DW + rmj_pkg::QuotW;

  logic [W-1:0]              num_w, den_w;
  logic [W-1:0]              rem_w [0:rmj_pkg::QuotW];
  logic [W-1:0]              div_w [0:rmj_pkg::QuotW];
  logic [rmj_pkg::QuotW-1:0] quo_w [0:rmj_pkg::QuotW];
  logic                      ovf_w [0:rmj_pkg::QuotW];
  logic [W-1:0]              rem0_q, div0_q;
  logic                      ovf0_q;

  assign num_w = W'(num_i);
  assign den_w = W'(den_i);

  // quotient wider than the output word saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem0_q <= num_w;
      div0_q <= den_w;
      ovf0_q <= (num_w >= (den_w << rmj_pkg::QuotW));
    end
  end

  assign rem_w[0] = rem0_q;
  assign div_w[0] = div0_q;
  assign quo_w[0] = '0;
  assign ovf_w[0] = ovf0_q;

  for (genvar k = 0; k < rmj_pkg::QuotW; k++) begin : g_cell
    rmj_div_cell #(
      .W   (W),
      .BIT (rmj_pkg::QuotW - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (rem_w[k]),
      .div_i (div_w[k]),
      .quo_i (quo_w[k]),
      .ovf_i (ovf_w[k]),
      .rem_o (rem_w[k+1]),
      .div_o (div_w[k+1]),
      .quo_o (quo_w[k+1]),
      .ovf_o (ovf_w[k+1])
    );
  end

  assign quo_o = quo_w[rmj_pkg::QuotW];
  assign ovf_o = ovf_w[rmj_pkg::QuotW];

endmodule

// File: hdl/radar_measurement_jacobian_top.sv
// Radar measurement Jacobian of a tracked state (px, py, vx, vy), signed fixed point.
// Input channel in_valid_i / in_ready_o / in_data_i carries one state per transaction;
// output channel out_valid_o / out_ready_i / out_data_o carries the six Jacobian
// entries and the singular flag. cfg_valid_i / cfg_data_i write the squared range
// threshold; cfg_ready_o is always high, write only while the block is idle.
// Throughput: one transaction per cycle while the skid register is empty, set by the
// square root row (one root bit per cell) and the six divider rows (one quotient bit
// per cell) behind it. Every stage moves forward in the same cycle; results leave
// through an output register with one skid register behind it.
// When the receiver stalls, the output register holds, the next result fills the
// skid register and then the whole pipeline freezes and in_ready_o drops, until
// the output is taken again.
// Reset clears all valid bits and sets the threshold to 7; no flush is needed.
`include "radar_measurement_jacobian_top_macros.svh"

module radar_measurement_jacobian_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  rmj_pkg::in_t              in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output rmj_pkg::out_t             out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [rmj_pkg::DataW-1:0] cfg_data_i
);

  localparam int unsigned DW  = rmj_pkg::DataW;
  localparam int unsigned NW0 = DW + FRAC_BITS;
  localparam int unsigned NW2 = DW + 2 * FRAC_BITS;
  localparam int unsigned NW4 = 3 * DW + FRAC_BITS;
  localparam int unsigned R3W = 3 * DW;
  localparam int unsigned Lat = 5 + rmj_pkg::SqrtSteps + rmj_pkg::QuotW;

  typedef struct packed {
    logic              sing;
    logic [5:0]        neg;
  } flg_t;

  typedef struct packed {
    logic [DW-1:0]     apx;
    logic [DW-1:0]     apy;
    logic [2*DW-1:0]   sqx;
    logic [2*DW-1:0]   sqy;
    logic signed [2*DW-1:0] ca;
    logic signed [2*DW-1:0] cb;
    logic              sx;
    logic              sy;
    logic              ypos;
  } s0_t;

  typedef struct packed {
    logic [DW-1:0]     apx;
    logic [DW-1:0]     apy;
    logic [2*DW-1:0]   r2;
    logic [2*DW-1:0]   cmag;
    logic              cneg;
    logic              sx;
    logic              sy;
    logic              ypos;
    logic              sing;
  } pay_t;

  typedef struct packed {
    logic [DW-1:0]     rho;
    logic [2*DW-1:0]   r2;
    logic [DW-1:0]     apx;
    logic [DW-1:0]     apy;
    logic [2*DW-1:0]   r3lo;
    logic [2*DW-1:0]   r3hi;
    logic [2*DW-1:0]   ylo;
    logic [2*DW-1:0]   yhi;
    logic [2*DW-1:0]   xlo;
    logic [2*DW-1:0]   xhi;
    flg_t              flg;
  } m1_t;

  typedef struct packed {
    logic [DW-1:0]     rho;
    logic [2*DW-1:0]   r2;
    logic [DW-1:0]     apx;
    logic [DW-1:0]     apy;
    logic [R3W-1:0]    r3;
    logic [R3W-1:0]    ny;
    logic [R3W-1:0]    nx;
    flg_t              flg;
  } m2_t;

  logic                  en;
  logic                  in_acc;
  logic [Lat-1:0]        vld_q;
  logic [DW-1:0]         mrs_q;
  logic [2*DW-1:0]       thr;
  s0_t                   s0_d, s0_q;
  pay_t                  pay_d;
  pay_t                  pay_q [0:rmj_pkg::SqrtSteps];
  rmj_pkg::sqrt_t        sq_w  [0:rmj_pkg::SqrtSteps];
  m1_t                   m1_d, m1_q;
  m2_t                   m2_d, m2_q;
  flg_t                  flg_q [0:rmj_pkg::QuotW];
  logic [rmj_pkg::QuotW-1:0] quo [0:5];
  logic [5:0]            ovf;
  rmj_pkg::out_t         res;
  rmj_pkg::out_t         o_q, s_q;
  logic                  o_valid_q, s_valid_q;
  logic                  o_free, p_in;
  pay_t                  pl;

  function automatic logic signed [DW-1:0] sat_q(input logic neg, input logic ovf_b,
                                                  input logic [DW-1:0] q);
    logic signed [DW-1:0] r;
    if (neg) begin
      if (ovf_b || q > {1'b1, {(DW-1){1'b0}}}) r = {1'b1, {(DW-1){1'b0}}};
      else r = -q;
    end else begin
      if (ovf_b || q[DW-1]) r = {1'b0, {(DW-1){1'b1}}};
      else r = q;
    end
    return r;
  endfunction

  // the whole pipeline advances unless the skid register holds a result
  assign en          = !s_valid_q;
  assign in_ready_o  = en;
  assign in_acc      = in_valid_i && en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mrs_q <= DW'(7);
    end else if (cfg_valid_i) begin
      mrs_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  // magnitudes, squares and cross products
  always_comb begin
    s0_d.sx   = in_data_i.pos_x[DW-1];
    s0_d.sy   = in_data_i.pos_y[DW-1];
    s0_d.ypos = !in_data_i.pos_y[DW-1] && (in_data_i.pos_y != '0);
    s0_d.apx  = s0_d.sx ? DW'(-in_data_i.pos_x) : DW'(in_data_i.pos_x);
    s0_d.apy  = s0_d.sy ? DW'(-in_data_i.pos_y) : DW'(in_data_i.pos_y);
    s0_d.sqx  = s0_d.apx * s0_d.apx;
    s0_d.sqy  = s0_d.apy * s0_d.apy;
    s0_d.ca   = in_data_i.vel_x * in_data_i.pos_y;
    s0_d.cb   = in_data_i.vel_y * in_data_i.pos_x;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= s0_d;
    end
  end

  assign thr = (2*DW)'(mrs_q) << FRAC_BITS;

  always_comb begin
    pay_d.apx  = s0_q.apx;
    pay_d.apy  = s0_q.apy;
    pay_d.sx   = s0_q.sx;
    pay_d.sy   = s0_q.sy;
    pay_d.ypos = s0_q.ypos;
    pay_d.r2   = s0_q.sqx + s0_q.sqy;
    pay_d.sing = (pay_d.r2 == '0) || (pay_d.r2 < thr);
    pay_d.cneg = (s0_q.ca < s0_q.cb);
    pay_d.cmag = pay_d.cneg ? $unsigned(s0_q.cb - s0_q.ca) : $unsigned(s0_q.ca - s0_q.cb);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pay_q[0] <= pay_d;
      for (int k = 0; k < rmj_pkg::SqrtSteps; k++) begin
        pay_q[k+1] <= pay_q[k];
      end
    end
  end

  assign sq_w[0].rem  = pay_q[0].r2;
  assign sq_w[0].root = '0;

  for (genvar k = 0; k < rmj_pkg::SqrtSteps; k++) begin : g_sqrt
    rmj_sqrt_cell #(
      .STEP (k)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq_w[k]),
      .sq_o  (sq_w[k+1])
    );
  end

  assign pl = pay_q[rmj_pkg::SqrtSteps];

  // 64x32 products split into 32x32 halves
  always_comb begin
    m1_d.rho  = sq_w[rmj_pkg::SqrtSteps].root[DW-1:0];
    m1_d.r2   = pl.r2;
    m1_d.apx  = pl.apx;
    m1_d.apy  = pl.apy;
    m1_d.r3lo = pl.r2[DW-1:0] * m1_d.rho;
    m1_d.r3hi = pl.r2[2*DW-1:DW] * m1_d.rho;
    m1_d.ylo  = pl.cmag[DW-1:0] * pl.apy;
    m1_d.yhi  = pl.cmag[2*DW-1:DW] * pl.apy;
    m1_d.xlo  = pl.cmag[DW-1:0] * pl.apx;
    m1_d.xhi  = pl.cmag[2*DW-1:DW] * pl.apx;
    m1_d.flg.sing   = pl.sing;
    m1_d.flg.neg[0] = pl.sx;
    m1_d.flg.neg[1] = pl.sy;
    m1_d.flg.neg[2] = pl.ypos;
    m1_d.flg.neg[3] = pl.sx;
    m1_d.flg.neg[4] = pl.sy ^ pl.cneg;
    m1_d.flg.neg[5] = pl.sx ^ !pl.cneg;
  end

  always_comb begin
    m2_d.rho = m1_q.rho;
    m2_d.r2  = m1_q.r2;
    m2_d.apx = m1_q.apx;
    m2_d.apy = m1_q.apy;
    m2_d.flg = m1_q.flg;
    m2_d.r3  = R3W'(m1_q.r3lo) + {m1_q.r3hi, {DW{1'b0}}};
    m2_d.ny  = R3W'(m1_q.ylo) + {m1_q.yhi, {DW{1'b0}}};
    m2_d.nx  = R3W'(m1_q.xlo) + {m1_q.xhi, {DW{1'b0}}};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_q <= m1_d;
      m2_q <= m2_d;
      flg_q[0] <= m2_q.flg;
      for (int k = 0; k < rmj_pkg::QuotW; k++) begin
        flg_q[k+1] <= flg_q[k];
      end
    end
  end

  rmj_div_chain #(.NW(NW0), .DW(DW)) u_div0 (
    .clk_i (clk_i), .en_i (en),
    .num_i (NW0'(m2_q.apx) << FRAC_BITS), .den_i (m2_q.rho),
    .quo_o (quo[0]), .ovf_o (ovf[0])
  );

  rmj_div_chain #(.NW(NW0), .DW(DW)) u_div1 (
    .clk_i (clk_i), .en_i (en),
    .num_i (NW0'(m2_q.apy) << FRAC_BITS), .den_i (m2_q.rho),
    .quo_o (quo[1]), .ovf_o (ovf[1])
  );

  rmj_div_chain #(.NW(NW2), .DW(2*DW)) u_div2 (
    .clk_i (clk_i), .en_i (en),
    .num_i (NW2'(m2_q.apy) << (2 * FRAC_BITS)), .den_i (m2_q.r2),
    .quo_o (quo[2]), .ovf_o (ovf[2])
  );

  rmj_div_chain #(.NW(NW2), .DW(2*DW)) u_div3 (
    .clk_i (clk_i), .en_i (en),
    .num_i (NW2'(m2_q.apx) << (2 * FRAC_BITS)), .den_i (m2_q.r2),
    .quo_o (quo[3]), .ovf_o (ovf[3])
  );

  rmj_div_chain #(.NW(NW4), .DW(R3W)) u_div4 (
    .clk_i (clk_i), .en_i (en),
    .num_i (NW4'(m2_q.ny) << FRAC_BITS), .den_i (m2_q.r3),
    .quo_o (quo[4]), .ovf_o (ovf[4])
  );

  rmj_div_chain #(.NW(NW4), .DW(R3W)) u_div5 (
    .clk_i (clk_i), .en_i (en),
    .num_i (NW4'(m2_q.nx) << FRAC_BITS), .den_i (m2_q.r3),
    .quo_o (quo[5]), .ovf_o (ovf[5])
  );

  always_comb begin
    if (flg_q[rmj_pkg::QuotW].sing) begin
      res          = '0;
      res.singular = 1'b1;
    end else begin
      res.drho_dpx  = sat_q(flg_q[rmj_pkg::QuotW].neg[0], ovf[0], quo[0]);
      res.drho_dpy  = sat_q(flg_q[rmj_pkg::QuotW].neg[1], ovf[1], quo[1]);
      res.dphi_dpx  = sat_q(flg_q[rmj_pkg::QuotW].neg[2], ovf[2], quo[2]);
      res.dphi_dpy  = sat_q(flg_q[rmj_pkg::QuotW].neg[3], ovf[3], quo[3]);
      res.drate_dpx = sat_q(flg_q[rmj_pkg::QuotW].neg[4], ovf[4], quo[4]);
      res.drate_dpy = sat_q(flg_q[rmj_pkg::QuotW].neg[5], ovf[5], quo[5]);
      res.singular  = 1'b0;
    end
  end

  // output register with one skid register behind it
  assign o_free = !o_valid_q || out_ready_i;
  assign p_in   = en && vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else if (o_free) begin
      if (s_valid_q) begin
        o_valid_q <= 1'b1;
        s_valid_q <= 1'b0;
      end else begin
        o_valid_q <= p_in;
      end
    end else if (p_in) begin
      s_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_free) begin
      o_q <= s_valid_q ? s_q : res;
    end else if (p_in) begin
      s_q <= res;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_q;

  `RMJ_ASSERT(a_skid_behind_out, s_valid_q |-> o_valid_q)
  `RMJ_ASSERT(a_stall_freezes, s_valid_q |=> $stable(vld_q))
  `RMJ_ASSERT(a_accept_enters, in_acc |=> vld_q[0])
  `RMJ_ASSERT(a_singular_zero, (out_valid_o && out_data_o.singular) |->
    (out_data_o.drho_dpx == '0 && out_data_o.drho_dpy == '0 &&
     out_data_o.dphi_dpx == '0 && out_data_o.dphi_dpy == '0 &&
     out_data_o.drate_dpx == '0 && out_data_o.drate_dpy == '0))
  `RMJ_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule
